// ===== hdl/sbx_pkg.sv =====
// shared types, constants and arithmetic helpers of the sbx crossover block
package sbx_pkg;

	localparam int VALUE_W = 32;
	localparam int RAND_W  = 16;
	localparam int CFG_W   = 16;
	localparam int CNT_W   = 32;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [CFG_W-1:0] CROSS_PROB_RST = 16'd58982;
	localparam logic [CFG_W-1:0] DIST_INDEX_RST = 16'd5120;
	localparam logic [CFG_W-1:0] MIN_DIFF_RST   = 16'd1;
	localparam logic [RAND_W-1:0] RAND_HALF     = 16'h8000;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_CROSS_PROB = 2'd0,
		REG_DIST_INDEX = 2'd1,
		REG_MIN_DIFF   = 2'd2
	} reg_idx_t;

	// pipeline section lengths of the spread unit
	localparam int BETA_DIV_STEPS = 49;
	localparam int LOG_STEPS      = 16;
	localparam int POW_STEPS      = 16;
	localparam int EXP_DIV_STEPS  = 29;

	// register index of each section inside the spread unit
	localparam int GB1  = BETA_DIV_STEPS + 1;
	localparam int GB2  = GB1 + 1;
	localparam int GL1  = GB2 + 1;
	localparam int GX   = GL1 + LOG_STEPS + 1;
	localparam int GP1  = GX + 1;
	localparam int GAL  = GP1 + POW_STEPS + 1;
	localparam int GUA  = GAL + 1;
	localparam int GSEL = GUA + 1;
	localparam int GM2  = GSEL + 1;
	localparam int GL2  = GM2 + 1;
	localparam int GQ   = GL2 + LOG_STEPS + 1;
	localparam int GP2  = GQ + EXP_DIV_STEPS + 1;
	localparam int GBQ  = GP2 + POW_STEPS + 1;
	localparam int GPA  = GBQ + 1;
	localparam int GPB  = GPA + 1;
	localparam int SPR_LAT = GPB + 1;

	// front stage word
	typedef struct packed {
		logic [VALUE_W-1:0] p1;
		logic [VALUE_W-1:0] p2;
		logic [VALUE_W-1:0] yl;
		logic [VALUE_W-1:0] yu;
		logic [RAND_W-1:0]  r_var;
		logic [RAND_W-1:0]  r_spread;
		logic [RAND_W-1:0]  r_swap;
		logic               act;
		logic [CNT_W-1:0]   count;
	} sbx_front_t;

	// side data that travels next to the spread units
	typedef struct packed {
		logic [VALUE_W-1:0] p1;
		logic [VALUE_W-1:0] p2;
		logic [VALUE_W-1:0] yl;
		logic [VALUE_W-1:0] yu;
		logic [VALUE_W:0]   sum;
		logic               xvar;
		logic               swap;
		logic [CNT_W-1:0]   count;
	} sbx_side_t;

	// exact integer square root, elaboration use only
	function automatic logic [63:0] isqrt64(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] v;
		r = '0;
		b = 64'd1 << 62;
		v = x;
		for (int i = 0; i < 32; i++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^k/65536) in Q1.30 from the chain of square roots of two
	function automatic logic [30:0] pow2_root(int k);
		logic [63:0] root;
		root = 64'd1 << 31;
		for (int j = 15; j >= k; j--) begin
			root = isqrt64(root << 30);
		end
		return root[30:0];
	endfunction

	// one log2 squaring step: {fraction bit, next mantissa}
	function automatic logic [31:0] sq_step(logic [30:0] y);
		logic [61:0] p;
		logic [31:0] t;
		p = 62'(y) * 62'(y);
		t = p[61:30];
		return t[31] ? {1'b1, t[31:1]} : {1'b0, t[30:0]};
	endfunction

	// Q1.30 product, truncated
	function automatic logic [30:0] pow_step(logic [30:0] r, logic [30:0] root);
		logic [61:0] p;
		p = 62'(r) * 62'(root);
		return p[60:30];
	endfunction

	// position of the leading one
	function automatic logic [5:0] lead_one(logic [49:0] v);
		logic [5:0] m;
		m = '0;
		for (int i = 0; i < 50; i++) begin
			if (v[i]) m = 6'(i);
		end
		return m;
	endfunction

endpackage

// ===== hdl/sbx_in_if.sv =====
// input channel: one variable of a parent pair per word
interface sbx_in_if;
	logic                                valid;
	logic                                ready;
	logic                                first_var;
	logic signed [sbx_pkg::VALUE_W-1:0]  parent1_value;
	logic signed [sbx_pkg::VALUE_W-1:0]  parent2_value;
	logic signed [sbx_pkg::VALUE_W-1:0]  lower_bound;
	logic signed [sbx_pkg::VALUE_W-1:0]  upper_bound;
	logic        [sbx_pkg::RAND_W-1:0]   rand_pair;
	logic        [sbx_pkg::RAND_W-1:0]   rand_var;
	logic        [sbx_pkg::RAND_W-1:0]   rand_spread;
	logic        [sbx_pkg::RAND_W-1:0]   rand_swap;

	modport source (output valid, first_var, parent1_value, parent2_value, lower_bound,
		upper_bound, rand_pair, rand_var, rand_spread, rand_swap, input ready);
	modport sink (input valid, first_var, parent1_value, parent2_value, lower_bound,
		upper_bound, rand_pair, rand_var, rand_spread, rand_swap, output ready);
endinterface

// ===== hdl/sbx_out_if.sv =====
// output channel: two children per word
interface sbx_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [sbx_pkg::VALUE_W-1:0]  child1_value;
	logic signed [sbx_pkg::VALUE_W-1:0]  child2_value;
	logic                                var_crossed;
	logic        [sbx_pkg::CNT_W-1:0]    pairs_crossed;

	modport source (output valid, child1_value, child2_value, var_crossed, pairs_crossed,
		input ready);
	modport sink (input valid, child1_value, child2_value, var_crossed, pairs_crossed,
		output ready);
endinterface

// ===== hdl/sbx_spread.sv =====
// pipelined sbx spread factor and its product with the parent distance
module sbx_spread (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] room,
	input  logic [31:0] diff,
	input  logic [15:0] u,
	input  logic [16:0] eta1,
	output logic [36:0] prod
);
	import sbx_pkg::*;

	// distance and random delay lines
	logic [31:0] dd_s [0:GPA-1];
	logic [15:0] uu_s [0:GUA-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s[0] <= diff;
			uu_s[0] <= u;
		end
	end
	for (genvar k = 1; k < GPA; k++) begin : g_dd
		always_ff @(posedge clk) begin
			if (en) dd_s[k] <= dd_s[k-1];
		end
	end
	for (genvar k = 1; k < GUA; k++) begin : g_uu
		always_ff @(posedge clk) begin
			if (en) uu_s[k] <= uu_s[k-1];
		end
	end

	// beta quotient: (room << 17) / diff, one bit per stage
	logic [48:0] an_s [0:BETA_DIV_STEPS];
	logic [31:0] ar_s [0:BETA_DIV_STEPS];
	logic [48:0] aq_s [0:BETA_DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			an_s[0] <= {room, 17'd0};
			ar_s[0] <= '0;
			aq_s[0] <= '0;
		end
	end
	for (genvar i = 0; i < BETA_DIV_STEPS; i++) begin : g_diva
		logic [32:0] t;
		logic        ge;
		assign t  = {ar_s[i], an_s[i][48]};
		assign ge = t >= {1'b0, dd_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				an_s[i+1] <= {an_s[i][47:0], 1'b0};
				ar_s[i+1] <= ge ? 32'(t - {1'b0, dd_s[i]}) : t[31:0];
				aq_s[i+1] <= {aq_s[i][47:0], ge};
			end
		end
	end

	// beta and its leading one
	logic [49:0] beta_b1, beta_b2;
	logic [5:0]  m_b2;

	always_ff @(posedge clk) begin
		if (en) begin
			beta_b1 <= 50'(aq_s[BETA_DIV_STEPS]) + 50'd65536;
			beta_b2 <= beta_b1;
			m_b2    <= lead_one(beta_b1);
		end
	end

	// log2 of beta by repeated squaring
	logic [30:0] l1y_s [0:LOG_STEPS];
	logic [15:0] l1f_s [0:LOG_STEPS];
	logic [5:0]  l1i_s [0:LOG_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			l1y_s[0] <= (m_b2 >= 6'd30) ? 31'(beta_b2 >> (m_b2 - 6'd30))
				: 31'(beta_b2 << (6'd30 - m_b2));
			l1i_s[0] <= m_b2 - 6'd16;
			l1f_s[0] <= '0;
		end
	end
	for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log1
		logic [31:0] st;
		assign st = sq_step(l1y_s[j]);
		always_ff @(posedge clk) begin
			if (en) begin
				l1y_s[j+1] <= st[30:0];
				l1f_s[j+1] <= {l1f_s[j][14:0], st[31]};
				l1i_s[j+1] <= l1i_s[j];
			end
		end
	end

	// exponent of alpha: log2(beta) * eta1
	logic [30:0] x_q;
	logic [38:0] x_full;
	assign x_full = 39'({l1i_s[LOG_STEPS], l1f_s[LOG_STEPS]}) * 39'(eta1);
	always_ff @(posedge clk) begin
		if (en) x_q <= x_full[38:8];
	end

	// 2^-x through the root table
	logic [30:0] p1r_s [0:POW_STEPS];
	logic [15:0] p1g_s [0:POW_STEPS];
	logic [15:0] p1s_s [0:POW_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			p1r_s[0] <= 31'd1 << 30;
			p1g_s[0] <= 16'(17'd65536 - 17'(x_q[15:0]));
			p1s_s[0] <= (x_q[15:0] == 16'd0) ? 16'(x_q[30:16]) : 16'(x_q[30:16]) + 16'd1;
		end
	end
	for (genvar j = 0; j < POW_STEPS; j++) begin : g_pow1
		localparam logic [30:0] RT = pow2_root(POW_STEPS - 1 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				p1r_s[j+1] <= p1g_s[j][POW_STEPS-1-j] ? pow_step(p1r_s[j], RT) : p1r_s[j];
				p1g_s[j+1] <= p1g_s[j];
				p1s_s[j+1] <= p1s_s[j];
			end
		end
	end

	// alpha, u * alpha and the branch select
	logic [31:0] al_q;
	logic [30:0] ua_q;
	logic [47:0] ua_full;
	logic [30:0] lv_sel, lv_m2;
	logic [5:0]  m_sel;
	logic [4:0]  m_m2;
	logic        zf_s [GSEL:GBQ-1];
	logic        nf_s [GSEL:GBQ-1];

	assign ua_full = 48'(uu_s[GUA-1]) * 48'(al_q);
	assign m_sel   = lead_one(50'(lv_sel));
	always_ff @(posedge clk) begin
		if (en) begin
			al_q <= 32'h8000_0000 - ((p1s_s[POW_STEPS] >= 16'd63) ? 32'd0
				: 32'(p1r_s[POW_STEPS] >> p1s_s[POW_STEPS]));
			ua_q <= ua_full[46:16];
			zf_s[GSEL] <= ua_q == '0;
			nf_s[GSEL] <= ua_q <= 31'h4000_0000;
			lv_sel <= (ua_q <= 31'h4000_0000) ? ua_q : 31'(32'h8000_0000 - 32'(ua_q));
			lv_m2 <= lv_sel;
			m_m2 <= m_sel[4:0];
		end
	end
	for (genvar k = GSEL + 1; k < GBQ; k++) begin : g_flags
		always_ff @(posedge clk) begin
			if (en) begin
				zf_s[k] <= zf_s[k-1];
				nf_s[k] <= nf_s[k-1];
			end
		end
	end

	// log2 of the selected fraction
	logic [30:0] l2y_s [0:LOG_STEPS];
	logic [15:0] l2f_s [0:LOG_STEPS];
	logic [4:0]  l2e_s [0:LOG_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			l2y_s[0] <= lv_m2 << (5'd30 - m_m2);
			l2e_s[0] <= 5'd30 - m_m2;
			l2f_s[0] <= '0;
		end
	end
	for (genvar j = 0; j < LOG_STEPS; j++) begin : g_log2
		logic [31:0] st;
		assign st = sq_step(l2y_s[j]);
		always_ff @(posedge clk) begin
			if (en) begin
				l2y_s[j+1] <= st[30:0];
				l2f_s[j+1] <= {l2f_s[j][14:0], st[31]};
				l2e_s[j+1] <= l2e_s[j];
			end
		end
	end

	// exponent quotient: (-log2 << 8) / eta1
	logic [28:0] cn_s [0:EXP_DIV_STEPS];
	logic [16:0] cr_s [0:EXP_DIV_STEPS];
	logic [28:0] cq_s [0:EXP_DIV_STEPS];
	logic [20:0] q_neg;

	assign q_neg = {l2e_s[LOG_STEPS], 16'd0} - {5'd0, l2f_s[LOG_STEPS]};
	always_ff @(posedge clk) begin
		if (en) begin
			cn_s[0] <= {q_neg, 8'd0};
			cr_s[0] <= '0;
			cq_s[0] <= '0;
		end
	end
	for (genvar i = 0; i < EXP_DIV_STEPS; i++) begin : g_divc
		logic [17:0] t;
		logic        ge;
		assign t  = {cr_s[i], cn_s[i][28]};
		assign ge = t >= {1'b0, eta1};
		always_ff @(posedge clk) begin
			if (en) begin
				cn_s[i+1] <= {cn_s[i][27:0], 1'b0};
				cr_s[i+1] <= ge ? 17'(t - {1'b0, eta1}) : t[16:0];
				cq_s[i+1] <= {cq_s[i][27:0], ge};
			end
		end
	end

	// betaq: 2^-e or 2^e through the root table
	logic [30:0] p2r_s [0:POW_STEPS];
	logic [15:0] p2g_s [0:POW_STEPS];
	logic [13:0] p2s_s [0:POW_STEPS];
	logic [28:0] e2;
	logic [12:0] e2n;

	assign e2  = cq_s[EXP_DIV_STEPS];
	assign e2n = e2[28:16];
	always_ff @(posedge clk) begin
		if (en) begin
			p2r_s[0] <= 31'd1 << 30;
			if (nf_s[GP2-1]) begin
				p2g_s[0] <= 16'(17'd65536 - 17'(e2[15:0]));
				p2s_s[0] <= (e2[15:0] == 16'd0) ? 14'(e2n) : 14'(e2n) + 14'd1;
			end else begin
				p2g_s[0] <= e2[15:0];
				p2s_s[0] <= (e2n > 13'd32) ? 14'd32 : 14'(e2n);
			end
		end
	end
	for (genvar j = 0; j < POW_STEPS; j++) begin : g_pow2
		localparam logic [30:0] RT = pow2_root(POW_STEPS - 1 - j);
		always_ff @(posedge clk) begin
			if (en) begin
				p2r_s[j+1] <= p2g_s[j][POW_STEPS-1-j] ? pow_step(p2r_s[j], RT) : p2r_s[j];
				p2g_s[j+1] <= p2g_s[j];
				p2s_s[j+1] <= p2s_s[j];
			end
		end
	end

	// final scale of betaq
	logic [63:0] bq_q;
	always_ff @(posedge clk) begin
		if (en) begin
			if (zf_s[GBQ-1]) bq_q <= '0;
			else if (nf_s[GBQ-1])
				bq_q <= (p2s_s[POW_STEPS] >= 14'd63) ? 64'd0
					: 64'(p2r_s[POW_STEPS]) >> p2s_s[POW_STEPS];
			else bq_q <= 64'(p2r_s[POW_STEPS]) << p2s_s[POW_STEPS];
		end
	end

	// betaq * diff as partial products, then sum and saturate
	logic [63:0] m1_q;
	logic [61:0] m2_q;
	logic [33:0] m3_q;
	logic [66:0] psum;

	always_ff @(posedge clk) begin
		if (en) begin
			m1_q <= 64'(bq_q[61:30]) * 64'(dd_s[GPA-1]);
			m2_q <= 62'(bq_q[29:0]) * 62'(dd_s[GPA-1]);
			m3_q <= 34'(bq_q[63:62]) * 34'(dd_s[GPA-1]);
		end
	end
	assign psum = 67'(m1_q) + {1'b0, m3_q, 32'd0} + 67'(m2_q[61:30]);
	always_ff @(posedge clk) begin
		if (en) prod <= (psum > 67'(64'd1 << 36)) ? 37'(64'd1 << 36) : psum[36:0];
	end

endmodule

// ===== hdl/sbx_real_crossover_core.sv =====
// sbx crossover top level: pair decision, spread pipelines, clamp and apb registers
//
// Takes one variable word per clock while the output is not stalled and returns
// one child word per word, in order. The path is a front register, the spread
// pipeline (a 49-stage beta divider, two 16-stage log2 squaring chains, two
// 16-stage power-of-two chains and a 29-stage exponent divider) and the
// clamp/output register. The whole pipeline advances together whenever the
// output register is empty or being taken, so the input is ready exactly then.
module sbx_real_crossover_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sbx_pkg::ADDR_W-1:0]  paddr,
	input  logic [sbx_pkg::DATA_W-1:0]  pwdata,
	output logic [sbx_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	sbx_in_if.sink                      item,
	sbx_out_if.source                   result
);
	import sbx_pkg::*;

	logic en;

	// configuration registers
	logic [CFG_W-1:0] cp_q, di_q, md_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q <= CROSS_PROB_RST;
			di_q <= DIST_INDEX_RST;
			md_q <= MIN_DIFF_RST;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_CROSS_PROB: cp_q <= pwdata[CFG_W-1:0];
				REG_DIST_INDEX: di_q <= pwdata[CFG_W-1:0];
				REG_MIN_DIFF:   md_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_CROSS_PROB: prdata = DATA_W'(cp_q);
			REG_DIST_INDEX: prdata = DATA_W'(di_q);
			REG_MIN_DIFF:   prdata = DATA_W'(md_q);
			default:        prdata = '0;
		endcase
	end

	// pair decision and crossed pair count
	logic             pa_q;
	logic [CNT_W-1:0] cnt_q;
	logic             act_in;
	logic [CNT_W-1:0] cnt_in;
	logic             accept;

	assign accept = item.valid && en;
	assign act_in = item.first_var ? (item.rand_pair <= cp_q) : pa_q;
	assign cnt_in = (item.first_var && act_in) ? cnt_q + 1'b1 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q  <= 1'b0;
			cnt_q <= '0;
		end else if (accept) begin
			pa_q  <= act_in;
			cnt_q <= cnt_in;
		end
	end

	// front register
	sbx_front_t f_s1;
	logic       v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= item.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1.p1       <= item.parent1_value;
			f_s1.p2       <= item.parent2_value;
			f_s1.yl       <= item.lower_bound;
			f_s1.yu       <= item.upper_bound;
			f_s1.r_var    <= item.rand_var;
			f_s1.r_spread <= item.rand_spread;
			f_s1.r_swap   <= item.rand_swap;
			f_s1.act      <= act_in;
			f_s1.count    <= cnt_in;
		end
	end

	// ordered parents, distances and crossing decision
	logic               lt;
	logic [VALUE_W-1:0] y1, y2, diff, dist1, dist2;
	logic [VALUE_W:0]   dw, d1w, d2w;
	sbx_side_t          side_in;

	assign lt    = $signed(f_s1.p1) < $signed(f_s1.p2);
	assign y1    = lt ? f_s1.p1 : f_s1.p2;
	assign y2    = lt ? f_s1.p2 : f_s1.p1;
	assign dw    = {y2[VALUE_W-1], y2} - {y1[VALUE_W-1], y1};
	assign diff  = dw[VALUE_W-1:0];
	assign d1w   = {y1[VALUE_W-1], y1} - {f_s1.yl[VALUE_W-1], f_s1.yl};
	assign d2w   = {f_s1.yu[VALUE_W-1], f_s1.yu} - {y2[VALUE_W-1], y2};
	assign dist1 = d1w[VALUE_W] ? '0 : d1w[VALUE_W-1:0];
	assign dist2 = d2w[VALUE_W] ? '0 : d2w[VALUE_W-1:0];

	always_comb begin
		side_in.p1    = f_s1.p1;
		side_in.p2    = f_s1.p2;
		side_in.yl    = f_s1.yl;
		side_in.yu    = f_s1.yu;
		side_in.sum   = {y1[VALUE_W-1], y1} + {y2[VALUE_W-1], y2};
		side_in.xvar  = f_s1.act && (f_s1.r_var <= RAND_HALF) && (diff > VALUE_W'(md_q));
		side_in.swap  = f_s1.r_swap <= RAND_HALF;
		side_in.count = f_s1.count;
	end

	// spread pipelines for the lower and upper child
	logic [16:0] eta1;
	logic [36:0] prod1, prod2;

	assign eta1 = 17'(di_q) + 17'd256;

	sbx_spread u_spread_lo (
		.clk  (clk),
		.en   (en),
		.room (dist1),
		.diff (diff),
		.u    (f_s1.r_spread),
		.eta1 (eta1),
		.prod (prod1)
	);

	sbx_spread u_spread_hi (
		.clk  (clk),
		.en   (en),
		.room (dist2),
		.diff (diff),
		.u    (f_s1.r_spread),
		.eta1 (eta1),
		.prod (prod2)
	);

	// side data delay line matched to the spread latency
	sbx_side_t side_s [0:SPR_LAT-1];
	logic      sv_s   [0:SPR_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sv_s[0] <= 1'b0;
		else if (en) sv_s[0] <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) side_s[0] <= side_in;
	end
	for (genvar k = 1; k < SPR_LAT; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv_s[k] <= 1'b0;
			else if (en) sv_s[k] <= sv_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) side_s[k] <= side_s[k-1];
		end
	end

	// children, clamp and swap
	sbx_side_t                 sd;
	logic signed [VALUE_W+6:0] c1w, c2w, c1c, c2c, ylw, yuw;

	assign sd  = side_s[SPR_LAT-1];
	assign ylw = (VALUE_W+7)'($signed(sd.yl));
	assign yuw = (VALUE_W+7)'($signed(sd.yu));
	assign c1w = ((VALUE_W+7)'($signed(sd.sum)) - $signed({2'b00, prod1})) >>> 1;
	assign c2w = ((VALUE_W+7)'($signed(sd.sum)) + $signed({2'b00, prod2})) >>> 1;

	always_comb begin
		c1c = (c1w < ylw) ? ylw : c1w;
		if (c1c > yuw) c1c = yuw;
		c2c = (c2w < ylw) ? ylw : c2w;
		if (c2c > yuw) c2c = yuw;
	end

	// output register
	logic               out_v_q;
	logic [VALUE_W-1:0] o1_q, o2_q;
	logic               ox_q;
	logic [CNT_W-1:0]   ocnt_q;

	assign en = !out_v_q || result.ready;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= sv_s[SPR_LAT-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ox_q   <= sd.xvar;
			ocnt_q <= sd.count;
			if (!sd.xvar) begin
				o1_q <= sd.p1;
				o2_q <= sd.p2;
			end else if (sd.swap) begin
				o1_q <= c2c[VALUE_W-1:0];
				o2_q <= c1c[VALUE_W-1:0];
			end else begin
				o1_q <= c1c[VALUE_W-1:0];
				o2_q <= c2c[VALUE_W-1:0];
			end
		end
	end

	assign result.valid         = out_v_q;
	assign result.child1_value  = o1_q;
	assign result.child2_value  = o2_q;
	assign result.var_crossed   = ox_q;
	assign result.pairs_crossed = ocnt_q;

endmodule

// ===== tb/sv/sbx_crossover_checker.sv =====
// checker for the sbx crossover block: predicts every child word and compares it
module sbx_crossover_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [sbx_pkg::ADDR_W-1:0]  paddr,
	input  logic [sbx_pkg::DATA_W-1:0]  pwdata,
	sbx_in_if                           item,
	sbx_out_if                          result,
	output int                          fail_count,
	output int                          words_pending,
	output int                          crossed_seen
);
	import sbx_pkg::*;

	typedef bit [63:0] u64_t;
	typedef longint s64_t;

	localparam u64_t ONE_Q30 = u64_t'(1) << 30;
	localparam u64_t SPREAD_LIMIT = u64_t'(1) << 36;

	typedef struct packed {
		logic [VALUE_W-1:0] c1;
		logic [VALUE_W-1:0] c2;
		logic               crossed;
		logic [CNT_W-1:0]   count;
	} child_word_t;

	child_word_t child_queue[$];

	// register copies and pair state
	u64_t cross_prob, dist_index, min_diff;
	logic pair_on;
	logic [CNT_W-1:0] pair_total;

	function automatic u64_t int_sqrt(u64_t x);
		u64_t r, b;
		r = 0;
		b = u64_t'(1) << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(f/65536) in Q2.30
	function automatic u64_t frac_pow2(u64_t f);
		u64_t r, root;
		r = ONE_Q30;
		root = 2 * ONE_Q30;
		for (int k = 15; k >= 0; k--) begin
			root = int_sqrt(root << 30);
			if (f[k]) r = (r * root) >> 30;
		end
		return r;
	endfunction

	// log2 of v with fb fraction bits, signed Q.16
	function automatic s64_t log2_q16(u64_t v, int fb);
		int m;
		u64_t y;
		s64_t res;
		if (v == 0) return 0;
		m = 63;
		while (!v[m]) m--;
		y = (m >= 30) ? (v >> (m - 30)) : (v << (30 - m));
		res = s64_t'(m - fb) * 65536;
		for (int i = 15; i >= 0; i--) begin
			y = (y * y) >> 30;
			if (y >= 2 * ONE_Q30) begin
				y = y >> 1;
				res = res + (s64_t'(1) << i);
			end
		end
		return res;
	endfunction

	// 2^-x, x unsigned Q.16, Q2.30
	function automatic u64_t exp2_down(u64_t x);
		u64_t n, f, v, s;
		n = x >> 16;
		f = x & 64'hFFFF;
		if (f == 0) begin
			v = ONE_Q30;
			s = n;
		end else begin
			v = frac_pow2(65536 - f);
			s = n + 1;
		end
		return (s >= 63) ? 0 : (v >> s);
	endfunction

	// 2^x, integer part capped at 32, Q.30
	function automatic u64_t exp2_up(u64_t x);
		u64_t n;
		n = x >> 16;
		if (n > 32) n = 32;
		return frac_pow2(x & 64'hFFFF) << n;
	endfunction

	// spread factor betaq in Q.30 for one side
	function automatic u64_t spread_beta(s64_t room, s64_t d, u64_t u, u64_t eta1);
		u64_t beta, x, t, alpha, ua, w;
		s64_t q;
		if (room < 0) room = 0;
		beta = 65536 + (u64_t'(room) << 17) / u64_t'(d);
		x = (u64_t'(log2_q16(beta, 16)) * eta1) >> 8;
		t = exp2_down(x);
		alpha = 2 * ONE_Q30 - t;
		ua = (u * alpha) >> RAND_W;
		if (ua <= ONE_Q30) begin
			if (ua == 0) return 0;
			q = -log2_q16(ua, 30);
			return exp2_down((u64_t'(q) << 8) / eta1);
		end
		w = (ua < 2 * ONE_Q30) ? 2 * ONE_Q30 - ua : 1;
		q = -log2_q16(w, 30);
		return exp2_up((u64_t'(q) << 8) / eta1);
	endfunction

	// betaq times d, Q16.16, saturated
	function automatic s64_t spread_times(u64_t bq, s64_t d);
		u64_t hi, lo, ud, p;
		hi = bq >> 30;
		lo = bq & (ONE_Q30 - 1);
		ud = u64_t'(d);
		if (hi != 0 && hi > SPREAD_LIMIT / ud) return s64_t'(SPREAD_LIMIT);
		p = hi * ud + ((lo * ud) >> 30);
		if (p > SPREAD_LIMIT) p = SPREAD_LIMIT;
		return s64_t'(p);
	endfunction

	function automatic s64_t bound_clip(s64_t c, s64_t yl, s64_t yu);
		if (c < yl) c = yl;
		if (c > yu) c = yu;
		return c;
	endfunction

	// children of one crossed or copied variable
	function automatic child_word_t predict_children(logic active, s64_t p1, s64_t p2,
			s64_t yl, s64_t yu, u64_t rv, u64_t rs, u64_t rw, logic [CNT_W-1:0] cnt);
		child_word_t w;
		s64_t y1, y2, d, sum, c1, c2;
		u64_t eta1;
		w.c1 = p1[VALUE_W-1:0];
		w.c2 = p2[VALUE_W-1:0];
		w.crossed = 1'b0;
		w.count = cnt;
		if (active && rv <= u64_t'(RAND_HALF)) begin
			y1 = (p1 < p2) ? p1 : p2;
			y2 = (p1 < p2) ? p2 : p1;
			d = y2 - y1;
			if (u64_t'(d) > min_diff) begin
				eta1 = dist_index + 256;
				sum = y1 + y2;
				c1 = (sum - spread_times(spread_beta(y1 - yl, d, rs, eta1), d)) >>> 1;
				c2 = (sum + spread_times(spread_beta(yu - y2, d, rs, eta1), d)) >>> 1;
				c1 = bound_clip(c1, yl, yu);
				c2 = bound_clip(c2, yl, yu);
				if (rw <= u64_t'(RAND_HALF)) begin
					w.c1 = c2[VALUE_W-1:0];
					w.c2 = c1[VALUE_W-1:0];
				end else begin
					w.c1 = c1[VALUE_W-1:0];
					w.c2 = c2[VALUE_W-1:0];
				end
				w.crossed = 1'b1;
			end
		end
		return w;
	endfunction

	assign words_pending = child_queue.size();

	// track registers, predict accepted words, compare returned words
	always @(posedge clk or negedge arst_n) begin
		child_word_t exp_w, got_w;
		logic act;
		logic [CNT_W-1:0] cnt;
		if (!arst_n) begin
			cross_prob <= CROSS_PROB_RST;
			dist_index <= DIST_INDEX_RST;
			min_diff <= MIN_DIFF_RST;
			pair_on <= 1'b0;
			pair_total <= '0;
			fail_count <= 0;
			crossed_seen <= 0;
			child_queue.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_CROSS_PROB: cross_prob <= pwdata[CFG_W-1:0];
					REG_DIST_INDEX: dist_index <= pwdata[CFG_W-1:0];
					REG_MIN_DIFF:   min_diff <= pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				act = pair_on;
				cnt = pair_total;
				if (item.first_var) begin
					act = (u64_t'(item.rand_pair) <= cross_prob);
					if (act) cnt = cnt + 1;
				end
				pair_on <= act;
				pair_total <= cnt;
				child_queue.push_back(predict_children(act, item.parent1_value,
					item.parent2_value, item.lower_bound, item.upper_bound,
					item.rand_var, item.rand_spread, item.rand_swap, cnt));
			end
			if (result.valid && result.ready) begin
				got_w.c1 = result.child1_value;
				got_w.c2 = result.child2_value;
				got_w.crossed = result.var_crossed;
				got_w.count = result.pairs_crossed;
				if (got_w.crossed) crossed_seen <= crossed_seen + 1;
				if (child_queue.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10) $display("unexpected child word %h", got_w);
				end else begin
					exp_w = child_queue.pop_front();
					if (got_w !== exp_w) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch: expected c1=%h c2=%h x=%b n=%0d, got c1=%h c2=%h x=%b n=%0d",
								exp_w.c1, exp_w.c2, exp_w.crossed, exp_w.count,
								got_w.c1, got_w.c2, got_w.crossed, got_w.count);
					end
				end
			end
		end
	end
endmodule

// ===== tb/sv/tb_sbx_real_crossover_core.sv =====
// testbench top for the sbx crossover block: stimulus, flow control and verdict
module tb_sbx_real_crossover_core;
	import sbx_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	int fail_count, words_pending, crossed_seen;
	int send_idle_pct, recv_stall_pct;
	int words_sent, quiet_cycles;

	sbx_in_if item_ch();
	sbx_out_if res_ch();

	sbx_real_crossover_core dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item(item_ch), .result(res_ch)
	);

	sbx_crossover_checker checker_i (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata), .item(item_ch), .result(res_ch),
		.fail_count(fail_count), .words_pending(words_pending),
		.crossed_seen(crossed_seen)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// receiver stalls
	always @(negedge clk) begin
		res_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** sbx_real_crossover_core: FAILED **");
			$finish;
		end
	end

	// register write with a setup phase and then an access phase
	task automatic reg_write(reg_idx_t idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = ADDR_W'(idx) << 2;
		pwdata = DATA_W'(value);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic apply_setting(logic [15:0] cp, logic [15:0] eta, logic [15:0] md);
		reg_write(REG_CROSS_PROB, cp);
		reg_write(REG_DIST_INDEX, eta);
		reg_write(REG_MIN_DIFF, md);
	endtask

	task automatic wait_drained();
		while (words_pending != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// send one variable word, called at a falling edge
	task automatic send_word(logic fv, logic [31:0] p1, logic [31:0] p2, logic [31:0] lo,
			logic [31:0] hi, logic [15:0] rp, logic [15:0] rv, logic [15:0] rs,
			logic [15:0] rw);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.first_var = fv;
		item_ch.parent1_value = p1;
		item_ch.parent2_value = p2;
		item_ch.lower_bound = lo;
		item_ch.upper_bound = hi;
		item_ch.rand_pair = rp;
		item_ch.rand_var = rv;
		item_ch.rand_spread = rs;
		item_ch.rand_swap = rw;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		item_ch.valid = 1'b0;
		words_sent++;
	endtask

	function automatic logic [15:0] pick_fraction();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return RAND_HALF;
			default: return 16'($urandom);
		endcase
	endfunction

	// one parent pair: mostly ordered bounds with parents inside, some noise
	task automatic send_pair();
		longint lo, hi, span, p1, p2, tmp;
		int nvars;
		logic [15:0] rv;
		nvars = $urandom_range(1, 8);
		for (int v = 0; v < nvars; v++) begin
			span = longint'($urandom) >> $urandom_range(0, 31);
			lo = longint'($signed($urandom)) >>> $urandom_range(0, 16);
			hi = lo + span;
			if (hi > 64'sd2147483647) hi = 64'sd2147483647;
			p1 = lo + (longint'($urandom) % (hi - lo + 1));
			p2 = lo + (longint'($urandom) % (hi - lo + 1));
			if ($urandom_range(0, 9) == 0) p1 = longint'($signed($urandom));
			if ($urandom_range(0, 9) == 0) p2 = longint'($signed($urandom));
			if ($urandom_range(0, 19) == 0) p2 = p1 + $urandom_range(0, 2);
			if ($urandom_range(0, 19) == 0) begin
				tmp = lo;
				lo = hi;
				hi = tmp;
			end
			rv = ($urandom_range(0, 3) == 0) ? pick_fraction() : 16'($urandom_range(0, 32768));
			send_word(v == 0, p1[31:0], p2[31:0], lo[31:0], hi[31:0], pick_fraction(), rv,
				pick_fraction(), pick_fraction());
		end
	endtask

	task automatic send_noise();
		send_word(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// directed words: copy before any pair, extremes and special cases
	task automatic send_directed();
		send_word(1'b0, 32'h0001_0000, 32'h0005_0000, 32'h0, 32'h000A_0000,
			16'h0, 16'h0, 16'h8000, 16'h0);
		send_word(1'b1, 32'h0002_0000, 32'h0006_0000, 32'h0, 32'h000A_0000,
			16'h0, 16'h0, 16'h8000, 16'h8000);
		send_word(1'b0, 32'h0002_0000, 32'h0006_0000, 32'h0, 32'h000A_0000,
			16'h0, 16'h0, 16'h8000, 16'h8001);
		send_word(1'b0, 32'h0002_0000, 32'h0006_0000, 32'h0, 32'h000A_0000,
			16'h0, 16'h8000, 16'h0000, 16'hFFFF);
		send_word(1'b0, 32'h0002_0000, 32'h0006_0000, 32'h0, 32'h000A_0000,
			16'h0, 16'h8001, 16'h4000, 16'h0);
		send_word(1'b0, 32'h0003_0000, 32'h0003_0000, 32'h0, 32'h000A_0000,
			16'h0, 16'h0, 16'h4000, 16'h0);
		send_word(1'b0, 32'h0003_0000, 32'h0003_0001, 32'h0, 32'h000A_0000,
			16'h0, 16'h0, 16'h4000, 16'h0);
		send_word(1'b0, 32'h0003_0000, 32'h0003_0002, 32'h0, 32'h000A_0000,
			16'h0, 16'h0, 16'hC000, 16'h0);
		send_word(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			16'h0, 16'h0, 16'hFFFF, 16'hFFFF);
		send_word(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			16'h0, 16'h0, 16'h0001, 16'h0);
		send_word(1'b0, 32'hFFFF_0000, 32'h0020_0000, 32'h0000_0000, 32'h0010_0000,
			16'h0, 16'h0, 16'h9000, 16'hFFFF);
		send_word(1'b0, 32'h0001_0000, 32'h0004_0000, 32'h000A_0000, 32'h0000_0000,
			16'h0, 16'h0, 16'h7000, 16'hFFFF);
		send_word(1'b0, 32'h0001_0000, 32'h0001_0100, 32'h0001_0000, 32'h0001_0100,
			16'h0, 16'h0, 16'hFFFF, 16'hFFFF);
		send_word(1'b1, 32'h0002_0000, 32'h0006_0000, 32'h0, 32'h000A_0000,
			16'hFFFF, 16'h0, 16'h8000, 16'h0);
		send_word(1'b0, 32'h0002_0000, 32'h0006_0000, 32'h0, 32'h000A_0000,
			16'hFFFF, 16'h0, 16'h8000, 16'h0);
		send_word(1'b1, 32'h0002_0000, 32'h0006_0000, 32'h0, 32'h000A_0000,
			16'hE666, 16'h0, 16'h8000, 16'h0);
		send_word(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'hE667, 16'hFFFF, 16'hFFFF, 16'hFFFF);
	endtask

	initial begin
		logic [15:0] cfg_cp[5];
		logic [15:0] cfg_eta[5];
		logic [15:0] cfg_md[5];
		int idle_mix[4][2];
		cfg_cp = '{16'd58982, 16'hFFFF, 16'h0000, 16'h8000, 16'hF000};
		cfg_eta = '{16'd5120, 16'h0000, 16'hFFFF, 16'h0100, 16'h0C00};
		cfg_md = '{16'd1, 16'h0000, 16'hFFFF, 16'h0040, 16'h0001};
		idle_mix = '{'{0, 0}, '{55, 0}, '{0, 55}, '{24, 24}};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		words_sent = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.first_var = 1'b0;
		item_ch.parent1_value = '0;
		item_ch.parent2_value = '0;
		item_ch.lower_bound = '0;
		item_ch.upper_bound = '0;
		item_ch.rand_pair = '0;
		item_ch.rand_var = '0;
		item_ch.rand_spread = '0;
		item_ch.rand_swap = '0;
		res_ch.ready = 1'b1;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_directed();
		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			apply_setting(cfg_cp[ph], cfg_eta[ph], cfg_md[ph]);
			for (int mix = 0; mix < 4; mix++) begin
				send_idle_pct = idle_mix[mix][0];
				recv_stall_pct = idle_mix[mix][1];
				for (int n = 0; n < 12; n++) begin
					if ($urandom_range(0, 9) == 0) send_noise();
					else send_pair();
				end
				// hold off until every child word is back
				if (mix == 1) wait_drained();
			end
		end

		send_idle_pct = 0;
		for (int k = 0; k < DRAIN_LIMIT && words_pending != 0; k++) @(posedge clk);
		repeat (SPR_LAT + 2) @(posedge clk);
		$display("sent %0d variable words over 5 register settings and 4 flow-control mixes,",
			words_sent);
		$display("%0d of them crossed, %0d words still outstanding", crossed_seen,
			words_pending);
		if (fail_count == 0 && words_pending == 0)
			$display("** sbx_real_crossover_core: PASSED **");
		else
			$display("** sbx_real_crossover_core: FAILED **");
		$finish;
	end
endmodule
